/* rtl/priority_bitmap_fifo_scheduler_top_defines.svh */
// Assertion macros shared by the checker of the priority bitmap FIFO scheduler.
// Depends on nothing; the including module must have i_clk and i_rst_n in scope.
// Each macro expands to one labelled concurrent assertion with a reset disable.
`ifndef PRIORITY_BITMAP_FIFO_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_BITMAP_FIFO_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PBFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PBFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pbfs_pkg.sv */
// Shared types and constants of the priority bitmap FIFO scheduler.
// Used by the ready queue, the top level, the checker and the testbench; depends on nothing.
package pbfs_pkg;

    localparam int TID_W     = 4;
    localparam int PRIO_W    = 3;
    localparam int ACT_W     = 3;
    localparam int LVL_OUT_W = 8;
    localparam int DEPTH_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_RUNNING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THREAD_ID = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_MAKE_READY     = 3'd0,
        ACT_MAKE_NOT_READY = 3'd1,
        ACT_YIELD          = 3'd2,
        ACT_SCHEDULE       = 3'd3,
        ACT_IRQ_ENTER      = 3'd4,
        ACT_IRQ_EXIT       = 3'd5,
        ACT_LOCK           = 3'd6,
        ACT_UNLOCK         = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_INSERT = 2'd1,
        Q_REMOVE = 2'd2,
        Q_YIELD  = 2'd3
    } t_q_op;

    typedef struct packed {
        logic              en;
        t_q_op             op;
        logic [TID_W-1:0]  tid;
        logic [PRIO_W-1:0] prio;
    } t_q_cmd;

    typedef struct packed {
        logic                 hit;
        logic [TID_W-1:0]     pick;
        logic [LVL_OUT_W-1:0] levels;
    } t_q_view;

endpackage

/* rtl/priority_bitmap_fifo_scheduler_top.sv */
// Top level of the priority bitmap FIFO scheduler: channels, configuration,
// nesting counters and result register. Depends on pbfs_pkg and pbfs_ready_queue.
//
//  Channel   Direction  Handshake                   Carries
//  input     in         i_in_valid / o_in_stall     action, thread, priority, context
//  result    out        o_out_valid / i_out_stall   pick, reschedule, swap, status, bitmap
//  config    in         i_cfg_valid / o_cfg_ready   register index and data
//
// One item is taken per clock cycle while o_in_stall is low. A result passes through
// the input register and then the result register, with the combinational list
// update and the priority encoder over the level bitmap between them. Reset is
// synchronous and needs no clearing pass; it clears the configuration registers,
// both valid flags, the bitmap, the queued flags and the counters. A stalled result
// holds while one more item waits.
module priority_bitmap_fifo_scheduler_top
    import pbfs_pkg::*;
#(
    parameter int LEVELS  = 8,
    parameter int THREADS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [TID_W-1:0]     i_thread_id,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic                 i_still_waiting,
    input  logic [TID_W-1:0]     i_current_thread,
    input  logic                 i_in_interrupt,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TID_W-1:0]     o_chosen_thread,
    output logic                 o_reschedule,
    output logic                 o_swap_request,
    output logic                 o_status,
    output logic [LVL_OUT_W-1:0] o_ready_levels,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic             r_kernel_running;
    logic [TID_W-1:0] r_idle_id;

    // Input register.
    logic              r_in_valid;
    t_action           r_act;
    logic [TID_W-1:0]  r_tid;
    logic [PRIO_W-1:0] r_prio;
    logic              r_wait;
    logic [TID_W-1:0]  r_cur;
    logic              r_irq;

    // Nesting counters.
    logic [DEPTH_W-1:0] r_irq_depth;
    logic [DEPTH_W-1:0] r_lock_depth;
    logic [DEPTH_W-1:0] n_irq_depth;
    logic [DEPTH_W-1:0] n_lock_depth;

    // Result register.
    logic                 r_out_valid;
    logic [TID_W-1:0]     r_chosen;
    logic                 r_resched;
    logic                 r_swap;
    logic                 r_status;
    logic [LVL_OUT_W-1:0] r_levels;
    logic                 n_resched;
    logic                 n_swap;
    logic                 n_status;

    logic    advance;
    logic    in_xfer;
    logic    irq_ok;
    t_q_cmd  q_cmd;
    t_q_view q_view;

    // The input register moves on whenever the result register is free or
    // its current result is being transferred in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_running <= 1'b0;
            r_idle_id        <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_KERNEL_RUNNING) begin
                r_kernel_running <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_IDLE_THREAD_ID) begin
                r_idle_id <= i_cfg_data[TID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act  <= t_action'(i_action);
            r_tid  <= i_thread_id;
            r_prio <= i_priority_req;
            r_wait <= i_still_waiting;
            r_cur  <= i_current_thread;
            r_irq  <= i_in_interrupt;
        end
    end

    // Queue operations; a thread that still waits is never made ready.
    always_comb begin
        q_cmd.tid  = r_tid;
        q_cmd.prio = r_prio;
        q_cmd.op   = Q_NONE;
        unique case (r_act)
            ACT_MAKE_READY:     q_cmd.op = r_wait ? Q_NONE : Q_INSERT;
            ACT_MAKE_NOT_READY: q_cmd.op = Q_REMOVE;
            ACT_YIELD:          q_cmd.op = Q_YIELD;
            default:            q_cmd.op = Q_NONE;
        endcase
        q_cmd.en = advance && (q_cmd.op != Q_NONE);
    end

    pbfs_ready_queue #(
        .LEVELS  (LEVELS),
        .THREADS (THREADS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_idle_id (r_idle_id),
        .o_view    (q_view)
    );

    // Counter updates and the swap decision. The queue is untouched by the
    // actions that decide a swap, so the pick shown by the queue is current.
    assign irq_ok = r_kernel_running && r_irq;

    always_comb begin
        n_irq_depth  = r_irq_depth;
        n_lock_depth = r_lock_depth;
        n_resched    = 1'b0;
        n_swap       = 1'b0;
        n_status     = 1'b0;
        unique case (r_act)
            ACT_YIELD: begin
                n_resched = q_view.hit && (q_view.pick != r_tid);
            end
            ACT_SCHEDULE: begin
                if (!r_kernel_running) begin
                    n_status = 1'b1;
                end else begin
                    n_swap = (r_lock_depth == '0) && (r_irq_depth == '0)
                             && (q_view.pick != r_cur);
                end
            end
            ACT_IRQ_ENTER: begin
                if (irq_ok && (r_irq_depth != DEPTH_MAX)) begin
                    n_irq_depth = r_irq_depth + DEPTH_W'(1);
                end
            end
            ACT_IRQ_EXIT: begin
                if (irq_ok && (r_irq_depth != '0)) begin
                    n_irq_depth = r_irq_depth - DEPTH_W'(1);
                    // Leaving the outermost interrupt decides on a switch.
                    n_swap = (n_irq_depth == '0) && (r_lock_depth == '0)
                             && (q_view.pick != r_cur);
                end
            end
            ACT_LOCK: begin
                if (r_lock_depth != DEPTH_MAX) begin
                    n_lock_depth = r_lock_depth + DEPTH_W'(1);
                end
            end
            ACT_UNLOCK: begin
                if (r_lock_depth != '0) begin
                    n_lock_depth = r_lock_depth - DEPTH_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_depth  <= '0;
            r_lock_depth <= '0;
        end else if (advance) begin
            r_irq_depth  <= n_irq_depth;
            r_lock_depth <= n_lock_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_chosen  <= q_view.pick;
            r_resched <= n_resched;
            r_swap    <= n_swap;
            r_status  <= n_status;
            r_levels  <= q_view.levels;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_thread = r_chosen;
    assign o_reschedule    = r_resched;
    assign o_swap_request  = r_swap;
    assign o_status        = r_status;
    assign o_ready_levels  = r_levels;

endmodule

/* rtl/pbfs_ready_queue.sv */
// Ready queue storage: per-level doubly linked FIFOs of thread ids and the level bitmap.
// Depends on pbfs_pkg. Applies one insert, remove or yield per enabled cycle and
// presents the pick and bitmap of the state that results.
module pbfs_ready_queue
    import pbfs_pkg::*;
#(
    parameter int LEVELS  = 8,
    parameter int THREADS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_cmd           i_cmd,
    input  logic [TID_W-1:0] i_idle_id,
    output t_q_view          o_view
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = (THREADS > 2) ? $clog2(THREADS) : 1;
    localparam int IW = (TW > TID_W) ? TW : TID_W;
    localparam int BW = (LEVELS > LVL_OUT_W) ? LEVELS : LVL_OUT_W;

    logic [TID_W-1:0] r_head [LEVELS];
    logic [TID_W-1:0] r_tail [LEVELS];
    logic [TID_W-1:0] r_next [THREADS];
    logic [TID_W-1:0] r_prev [THREADS];
    logic [LW-1:0]    r_lvl  [THREADS];
    logic [THREADS-1:0] r_queued;
    logic [LEVELS-1:0]  r_bitmap;

    logic [TID_W-1:0] n_head [LEVELS];
    logic [TID_W-1:0] n_tail [LEVELS];
    logic [TID_W-1:0] n_next [THREADS];
    logic [TID_W-1:0] n_prev [THREADS];
    logic [LW-1:0]    n_lvl  [THREADS];
    logic [THREADS-1:0] n_queued;
    logic [LEVELS-1:0]  n_bitmap;

    logic [TW-1:0]    idx;
    logic             tid_ok;
    logic             is_queued;
    logic             do_remove;
    logic             do_append;
    logic [LW-1:0]    prio_lv;
    logic [LW-1:0]    app_lv;
    logic [LW-1:0]    rem_lv;
    logic             is_head;
    logic             is_tail;
    logic [TID_W-1:0] link_n;
    logic [TID_W-1:0] link_p;
    logic [TID_W-1:0] tail_id;
    logic [TID_W-1:0] pick;
    logic [BW-1:0]    bm_ext;

    // Map a 4-bit thread id onto the index width of the thread stores.
    function automatic logic [TW-1:0] tidx(input logic [TID_W-1:0] t);
        logic [IW-1:0] w;
        w = IW'(t);
        return w[TW-1:0];
    endfunction

    assign idx       = tidx(i_cmd.tid);
    assign tid_ok    = 32'(i_cmd.tid) < THREADS;
    assign is_queued = tid_ok && r_queued[idx];
    assign prio_lv   = (32'(i_cmd.prio) >= LEVELS) ? LW'(LEVELS - 1) : LW'(i_cmd.prio);

    always_comb begin
        do_remove = 1'b0;
        do_append = 1'b0;
        app_lv    = prio_lv;
        if (i_cmd.en) begin
            case (i_cmd.op)
                Q_INSERT: begin
                    do_append = tid_ok && !r_queued[idx];
                end
                Q_REMOVE: begin
                    do_remove = is_queued;
                end
                Q_YIELD: begin
                    do_remove = is_queued;
                    do_append = is_queued;
                    app_lv    = r_lvl[idx];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_next   = r_next;
        n_prev   = r_prev;
        n_lvl    = r_lvl;
        n_queued = r_queued;
        n_bitmap = r_bitmap;

        rem_lv  = r_lvl[idx];
        is_head = r_head[rem_lv] == i_cmd.tid;
        is_tail = r_tail[rem_lv] == i_cmd.tid;
        link_n  = r_next[idx];
        link_p  = r_prev[idx];

        // Unlink from whichever position the thread holds in its level.
        if (do_remove) begin
            if (is_head && is_tail) begin
                n_bitmap[rem_lv] = 1'b0;
            end else if (is_head) begin
                n_head[rem_lv] = link_n;
            end else if (is_tail) begin
                n_tail[rem_lv] = link_p;
            end else begin
                n_next[tidx(link_p)] = link_n;
                n_prev[tidx(link_n)] = link_p;
            end
            n_queued[idx] = 1'b0;
        end

        // Append at the tail; works on the state left by the unlink above.
        tail_id = n_tail[app_lv];
        if (do_append) begin
            if (!n_bitmap[app_lv]) begin
                n_head[app_lv] = i_cmd.tid;
            end else begin
                n_next[tidx(tail_id)] = i_cmd.tid;
                n_prev[idx]           = tail_id;
            end
            n_tail[app_lv]   = i_cmd.tid;
            n_bitmap[app_lv] = 1'b1;
            n_lvl[idx]       = app_lv;
            n_queued[idx]    = 1'b1;
        end
    end

    // Highest set level wins, so later iterations override earlier ones.
    always_comb begin
        pick = i_idle_id;
        for (int i = 0; i < LEVELS; i++) begin
            if (n_bitmap[i]) begin
                pick = n_head[i];
            end
        end
    end

    assign bm_ext        = BW'(n_bitmap);
    assign o_view.hit    = is_queued;
    assign o_view.pick   = pick;
    assign o_view.levels = bm_ext[LVL_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_next <= n_next;
            r_prev <= n_prev;
            r_lvl  <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= '0;
            r_bitmap <= '0;
        end else if (i_cmd.en) begin
            r_queued <= n_queued;
            r_bitmap <= n_bitmap;
        end
    end

endmodule

/* rtl/pbfs_checker.sv */
// Port-level checker for the priority bitmap FIFO scheduler, bound to the top level.
// Depends on pbfs_pkg and the assertion macros in the scheduler's defines header.
`include "priority_bitmap_fifo_scheduler_top_defines.svh"

module pbfs_checker
    import pbfs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [TID_W-1:0]     o_chosen_thread,
    input logic                 o_reschedule,
    input logic                 o_swap_request,
    input logic                 o_status,
    input logic [LVL_OUT_W-1:0] o_ready_levels
);

    // A result held back by the receiver keeps its pick, swap request and bitmap.
    `PBFS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_chosen_thread) && $stable(o_swap_request)
            && $stable(o_ready_levels),
        "result changed while stalled")

    // An error answer never asks for a context switch.
    `PBFS_ASSERT_NOW(a_err_no_swap, o_out_valid && o_status,
        !o_swap_request && !o_reschedule, "error result carries a switch")

    // Only a yield flags a reschedule, and a yield never requests a swap.
    `PBFS_ASSERT_NOW(a_resched_excl, o_out_valid && o_reschedule,
        !o_swap_request, "reschedule and swap together")

    // With no result pending the input side is never held off.
    `PBFS_ASSERT_NEXT(a_no_stall_idle, !o_out_valid && !o_in_stall && !i_in_valid,
        !o_in_stall, "input stalled with nothing pending")

endmodule

bind priority_bitmap_fifo_scheduler_top pbfs_checker u_pbfs_checker (.*);

/* tb/tb_priority_bitmap_fifo_scheduler_top.sv */
// Self-checking testbench of the priority bitmap FIFO scheduler top level.
// Depends on pbfs_pkg and the RTL of priority_bitmap_fifo_scheduler_top; it
// models the ready queue itself and checks every result transfer against it.
module tb_priority_bitmap_fifo_scheduler_top
    import pbfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS       = 8;
    localparam int THREADS      = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 10;

    // There is no register at this index; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // One scheduler request as it travels on the input channel.
    typedef struct {
        t_action           act;
        logic [TID_W-1:0]  tid;
        logic [PRIO_W-1:0] prio;
        logic              waiting;
        logic [TID_W-1:0]  cur;
        logic              in_irq;
    } t_sched_op;

    // One scheduler answer as it travels on the result channel.
    typedef struct packed {
        logic [TID_W-1:0]     chosen;
        logic                 resched;
        logic                 swap;
        logic                 status;
        logic [LVL_OUT_W-1:0] levels;
    } t_sched_ans;

    // Ways in which the result side holds off transfers.
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_CHOPPY,
        RX_BURSTY
    } t_rx_mode;

    // Every input is given a known value from time zero.
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic [ACT_W-1:0]     i_action         = '0;
    logic [TID_W-1:0]     i_thread_id      = '0;
    logic [PRIO_W-1:0]    i_priority_req   = '0;
    logic                 i_still_waiting  = 1'b0;
    logic [TID_W-1:0]     i_current_thread = '0;
    logic                 i_in_interrupt   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic [TID_W-1:0]     o_chosen_thread;
    logic                 o_reschedule;
    logic                 o_swap_request;
    logic                 o_status;
    logic [LVL_OUT_W-1:0] o_ready_levels;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data       = '0;

    priority_bitmap_fifo_scheduler_top #(
        .LEVELS  (LEVELS),
        .THREADS (THREADS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_thread_id      (i_thread_id),
        .i_priority_req   (i_priority_req),
        .i_still_waiting  (i_still_waiting),
        .i_current_thread (i_current_thread),
        .i_in_interrupt   (i_in_interrupt),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_chosen_thread  (o_chosen_thread),
        .o_reschedule     (o_reschedule),
        .o_swap_request   (o_swap_request),
        .o_status         (o_status),
        .o_ready_levels   (o_ready_levels),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the ready queue. It is advanced once per accepted input
    // transfer, so its contents always describe the block after the last
    // request that the block has taken.
    // ------------------------------------------------------------------
    logic [LVL_OUT_W-1:0] lvl_map = '0;
    logic [TID_W-1:0]     lvl_head   [LEVELS];
    logic [TID_W-1:0]     lvl_tail   [LEVELS];
    logic [TID_W-1:0]     thr_next   [THREADS];
    logic [TID_W-1:0]     thr_prev   [THREADS];
    logic [PRIO_W-1:0]    thr_level  [THREADS];
    logic                 thr_queued [THREADS];
    int unsigned          irq_nest  = 0;
    int unsigned          lock_nest = 0;
    logic                 run_flag  = 1'b0;
    logic [TID_W-1:0]     idle_tid  = '0;

    // Requests waiting to be sent, and answers waiting to be received.
    t_sched_op  ops_to_send[$];
    t_sched_ans sched_answers[$];

    int unsigned ops_sent      = 0;
    int unsigned answers_seen  = 0;
    int unsigned resched_seen  = 0;
    int unsigned swaps_seen    = 0;
    int unsigned mismatches    = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count   = 0;

    initial begin
        for (int t = 0; t < THREADS; t++) thr_queued[t] = 1'b0;
    end

    // The pick is the head of the highest-numbered non-empty level.
    function automatic logic [TID_W-1:0] ready_pick();
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            if (lvl_map[lv]) return lvl_head[lv];
        end
        return idle_tid;
    endfunction

    function automatic void link_tail(logic [TID_W-1:0] t, logic [PRIO_W-1:0] lv);
        if (!lvl_map[lv]) begin
            lvl_head[lv] = t;
        end else begin
            thr_next[lvl_tail[lv]] = t;
            thr_prev[t]            = lvl_tail[lv];
        end
        lvl_tail[lv]  = t;
        lvl_map[lv]   = 1'b1;
        thr_level[t]  = lv;
        thr_queued[t] = 1'b1;
    endfunction

    function automatic void unlink(logic [TID_W-1:0] t);
        logic [PRIO_W-1:0] lv;
        logic              at_head;
        logic              at_tail;
        lv      = thr_level[t];
        at_head = (lvl_head[lv] == t);
        at_tail = (lvl_tail[lv] == t);
        if (at_head && at_tail) begin
            lvl_map[lv] = 1'b0;
        end else if (at_head) begin
            lvl_head[lv] = thr_next[t];
        end else if (at_tail) begin
            lvl_tail[lv] = thr_prev[t];
        end else begin
            thr_next[thr_prev[t]] = thr_next[t];
            thr_prev[thr_next[t]] = thr_prev[t];
        end
        thr_queued[t] = 1'b0;
    endfunction

    // A switch is wanted only outside interrupts and locks, and only when
    // the pick is not the thread already running.
    function automatic logic switch_wanted(logic [TID_W-1:0] cur);
        if (lock_nest > 0 || irq_nest > 0) return 1'b0;
        return ready_pick() != cur;
    endfunction

    function automatic t_sched_ans sched_step(t_sched_op op);
        t_sched_ans        ans;
        logic [PRIO_W-1:0] lv;
        logic              tid_ok;
        ans    = '0;
        lv     = (int'(op.prio) >= LEVELS) ? PRIO_W'(LEVELS - 1) : op.prio;
        tid_ok = int'(op.tid) < THREADS;
        case (op.act)
            ACT_MAKE_READY: begin
                if (tid_ok && !op.waiting && !thr_queued[op.tid]) link_tail(op.tid, lv);
            end
            ACT_MAKE_NOT_READY: begin
                if (tid_ok && thr_queued[op.tid]) unlink(op.tid);
            end
            ACT_YIELD: begin
                if (tid_ok && thr_queued[op.tid]) begin
                    lv = thr_level[op.tid];
                    unlink(op.tid);
                    link_tail(op.tid, lv);
                    ans.resched = (ready_pick() != op.tid);
                end
            end
            ACT_SCHEDULE: begin
                if (!run_flag) ans.status = 1'b1;
                else           ans.swap   = switch_wanted(op.cur);
            end
            ACT_IRQ_ENTER: begin
                if (run_flag && op.in_irq && irq_nest < DEPTH_MAX) irq_nest++;
            end
            ACT_IRQ_EXIT: begin
                if (run_flag && op.in_irq && irq_nest > 0) begin
                    irq_nest--;
                    if (irq_nest == 0) ans.swap = switch_wanted(op.cur);
                end
            end
            ACT_LOCK: begin
                if (lock_nest < DEPTH_MAX) lock_nest++;
            end
            default: begin
                if (lock_nest > 0) lock_nest--;
            end
        endcase
        ans.chosen = ready_pick();
        ans.levels = lvl_map;
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_sched_op mk_op(t_action act, int tid, int prio, bit waiting,
                                        int cur, bit in_irq);
        t_sched_op op;
        op.act     = act;
        op.tid     = TID_W'(tid);
        op.prio    = PRIO_W'(prio);
        op.waiting = waiting;
        op.cur     = TID_W'(cur);
        op.in_irq  = in_irq;
        return op;
    endfunction

    // Mostly well-formed traffic: removals and yields usually name a thread
    // that is queued, and the running thread is often the current pick, so
    // that the lists grow deep and both answers of the swap decision occur.
    function automatic t_sched_op rand_op();
        t_sched_op   op;
        int unsigned r;
        int unsigned start;
        r          = $urandom_range(0, 99);
        op.tid     = TID_W'($urandom);
        op.prio    = PRIO_W'($urandom);
        op.waiting = ($urandom_range(0, 9) == 0);
        op.in_irq  = ($urandom_range(0, 4) != 0);
        op.cur     = $urandom_range(0, 1) ? ready_pick() : TID_W'($urandom);
        if      (r < 30) op.act = ACT_MAKE_READY;
        else if (r < 45) op.act = ACT_MAKE_NOT_READY;
        else if (r < 65) op.act = ACT_YIELD;
        else if (r < 78) op.act = ACT_SCHEDULE;
        else if (r < 82) op.act = ACT_IRQ_ENTER;
        else if (r < 88) op.act = ACT_IRQ_EXIT;
        else if (r < 92) op.act = ACT_LOCK;
        else             op.act = ACT_UNLOCK;
        if ((op.act == ACT_MAKE_NOT_READY || op.act == ACT_YIELD) &&
            $urandom_range(0, 3) != 0) begin
            start = $urandom_range(0, THREADS - 1);
            for (int k = 0; k < THREADS; k++) begin
                if (thr_queued[(start + k) % THREADS]) begin
                    op.tid = TID_W'((start + k) % THREADS);
                    break;
                end
            end
        end
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Driver. A request stays on the port until its transfer; the choice to
    // present the next one depends on burst and gap counters and the send queue, never on
    // the stall, and the prediction is made at the edge of the transfer.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        t_sched_op nxt;
        logic      took;
        took = i_in_valid && !o_in_stall;
        if (took) begin
            sched_answers.push_back(sched_step(ops_to_send.pop_front()));
            ops_sent++;
            if (burst_left > 0) burst_left--;
        end
        if (!i_in_valid || took) begin
            if (burst_left == 0) begin
                gap_left   = $urandom_range(0, 6);
                // Now and then a long burst runs without any gap at all.
                burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
                nxt              = ops_to_send[0];
                i_in_valid       <= 1'b1;
                i_action         <= nxt.act;
                i_thread_id      <= nxt.tid;
                i_priority_req   <= nxt.prio;
                i_still_waiting  <= nxt.waiting;
                i_current_thread <= nxt.cur;
                i_in_interrupt   <= nxt.in_irq;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each result transfer is matched against the oldest waiting
    // answer; the stall follows a mode that changes every so often.
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode   = RX_FLOW;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        t_sched_ans got;
        t_sched_ans want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_chosen_thread, o_reschedule, o_swap_request, o_status, o_ready_levels};
            answers_seen++;
            if (got.resched) resched_seen++;
            if (got.swap)    swaps_seen++;
            if (sched_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result transfer with nothing outstanding:", $realtime,
                             " chosen %0d resched %0b swap %0b", got.chosen, got.resched,
                             got.swap, " status %0b levels %02h", got.status, got.levels);
            end else begin
                want = sched_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] result %0d wrong:", $realtime, answers_seen,
                                 " chosen %0d/%0d resched %0b/%0b", want.chosen,
                                 got.chosen, want.resched, got.resched,
                                 " swap %0b/%0b status %0b/%0b", want.swap, got.swap,
                                 want.status, got.status,
                                 " levels %02h/%02h (expected/actual)", want.levels,
                                 got.levels);
                end
            end
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_FLOW:   i_out_stall <= 1'b0;
            RX_CHOPPY: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (hold_left == 0 && $urandom_range(0, 7) == 0)
                    hold_left = $urandom_range(1, 10);
                i_out_stall <= (hold_left != 0);
                if (hold_left != 0) hold_left--;
            end
        endcase
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d answers outstanding",
                     CYCLE_LIMIT, sched_answers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing tasks.
    // ------------------------------------------------------------------

    // The caller must make a configuration write only while no request is in flight; the
    // task itself does not enforce it. The shadow copy is updated at the edge of its transfer.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KERNEL_RUNNING)      run_flag = data[0];
        else if (idx == CFG_IDLE_THREAD_ID) idle_tid = data;
        settings_used++;
    endtask

    // Waits until every request has been sent and answered, then lets the
    // two-stage pipeline settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (ops_to_send.size() != 0 || sched_answers.size() != 0 || i_in_valid);
        repeat (4) @(posedge i_clk);
    endtask

    // Random requests are generated a few at a time, so that the shadow
    // state used to shape them is close to the block's own.
    task automatic feed_random(input int n);
        for (int k = 0; k < n; k++) begin
            while (ops_to_send.size() >= 4) @(posedge i_clk);
            ops_to_send.push_back(rand_op());
        end
    endtask

    initial begin
        t_sched_op op;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stopped kernel; the upper data bits of the run flag carry no meaning.
        cfg_write(CFG_KERNEL_RUNNING, 4'b1110);
        cfg_write(CFG_IDLE_THREAD_ID, 4'd5);
        cfg_write(CFG_UNUSED_INDEX, 4'hF);

        // Directed requests with the kernel stopped.
        ops_to_send.push_back(mk_op(ACT_SCHEDULE, 0, 0, 0, 0, 0));   // error status
        ops_to_send.push_back(mk_op(ACT_IRQ_ENTER, 0, 0, 0, 15, 1)); // ignored
        ops_to_send.push_back(mk_op(ACT_IRQ_EXIT, 0, 0, 0, 15, 1));  // ignored
        ops_to_send.push_back(mk_op(ACT_LOCK, 0, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_UNLOCK, 0, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_UNLOCK, 15, 7, 1, 15, 1));   // unlock already at zero
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 0, 0, 1, 0, 0)); // still waiting
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 0, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 15, 7, 0, 15, 1));
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 15, 3, 0, 0, 0)); // already queued
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 7, 7, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 9, 7, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_YIELD, 7, 0, 0, 0, 0));      // from the middle
        ops_to_send.push_back(mk_op(ACT_YIELD, 15, 0, 0, 0, 0));     // from the head
        ops_to_send.push_back(mk_op(ACT_MAKE_NOT_READY, 7, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_MAKE_NOT_READY, 15, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_YIELD, 9, 0, 0, 0, 0));      // alone at its level
        ops_to_send.push_back(mk_op(ACT_MAKE_NOT_READY, 3, 0, 0, 0, 0)); // not queued
        ops_to_send.push_back(mk_op(ACT_YIELD, 3, 0, 0, 0, 0));          // not queued
        ops_to_send.push_back(mk_op(ACT_MAKE_NOT_READY, 9, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_MAKE_NOT_READY, 0, 0, 0, 0, 0)); // all empty
        wait_idle();

        // Running kernel with the highest idle id.
        cfg_write(CFG_KERNEL_RUNNING, 4'b0001);
        cfg_write(CFG_IDLE_THREAD_ID, 4'd15);
        ops_to_send.push_back(mk_op(ACT_SCHEDULE, 0, 0, 0, 15, 0));  // pick is running
        ops_to_send.push_back(mk_op(ACT_SCHEDULE, 0, 0, 0, 0, 0));   // switch needed
        ops_to_send.push_back(mk_op(ACT_MAKE_READY, 4, 2, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_LOCK, 0, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_SCHEDULE, 0, 0, 0, 0, 0));   // held by the lock
        ops_to_send.push_back(mk_op(ACT_UNLOCK, 0, 0, 0, 0, 0));
        ops_to_send.push_back(mk_op(ACT_IRQ_ENTER, 0, 0, 0, 0, 0));  // not in interrupt
        ops_to_send.push_back(mk_op(ACT_IRQ_ENTER, 0, 0, 0, 0, 1));
        ops_to_send.push_back(mk_op(ACT_SCHEDULE, 0, 0, 0, 0, 1));   // held by the interrupt
        ops_to_send.push_back(mk_op(ACT_IRQ_EXIT, 0, 0, 0, 0, 1));   // last exit decides
        ops_to_send.push_back(mk_op(ACT_IRQ_EXIT, 0, 0, 0, 0, 1));   // exit already at zero
        wait_idle();

        // Random traffic; halfway through the sender holds back until every
        // answer has been received.
        cfg_write(CFG_IDLE_THREAD_ID, TID_W'($urandom));
        feed_random(40);
        wait_idle();
        feed_random(30);
        wait_idle();

        cfg_write(CFG_KERNEL_RUNNING, {3'($urandom), 1'b0});
        cfg_write(CFG_IDLE_THREAD_ID, 4'd15);
        feed_random(40);
        wait_idle();

        // Drive both nesting counters into saturation and back down; the
        // schedules near the bottom show exactly where the lock is released.
        cfg_write(CFG_KERNEL_RUNNING, {3'($urandom), 1'b1});
        cfg_write(CFG_IDLE_THREAD_ID, 4'd0);
        for (int k = 0; k < 257; k++) begin
            op     = rand_op();
            op.act = ACT_LOCK;
            ops_to_send.push_back(op);
        end
        for (int k = 0; k < 257; k++) begin
            op     = rand_op();
            op.act = ACT_UNLOCK;
            ops_to_send.push_back(op);
            if (k >= 250) begin
                op.act = ACT_SCHEDULE;
                ops_to_send.push_back(op);
            end
        end
        for (int k = 0; k < 256; k++) begin
            op        = rand_op();
            op.act    = ACT_IRQ_ENTER;
            op.in_irq = 1'b1;
            ops_to_send.push_back(op);
        end
        for (int k = 0; k < 256; k++) begin
            op        = rand_op();
            op.act    = ACT_IRQ_EXIT;
            op.in_irq = 1'b1;
            ops_to_send.push_back(op);
        end
        wait_idle();

        feed_random(30);
        wait_idle();

        cfg_write(CFG_IDLE_THREAD_ID, TID_W'($urandom));
        feed_random(30);
        wait_idle();

        repeat (8) @(posedge i_clk);
        $display("checked %0d answers to %0d requests across %0d register writes",
                 answers_seen, ops_sent, settings_used);
        $display("%0d answers asked for a reschedule and %0d for a context switch",
                 resched_seen, swaps_seen);
        if (mismatches == 0 && sched_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d answers never received",
                     mismatches, sched_answers.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pbfs_pkg.sv
rtl/pbfs_ready_queue.sv
rtl/priority_bitmap_fifo_scheduler_top.sv
rtl/pbfs_checker.sv
tb/tb_priority_bitmap_fifo_scheduler_top.sv
